/* rtl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg
// Shared constants and types for the product-except-self block.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int MAX_ELEMS_DEF = 64;
   localparam int DATA_W        = 32;

   typedef struct packed {
      logic a_push;
      logic a_pop;
      logic b_push;
      logic b_pop;
   } pes_ctrl_type;

endpackage

/* rtl/product_except_self.sv */
// Operation: a vector loads one element per cycle, a backward pass then runs
// through the cell row, and a forward pass sends one result per cycle while
// the receiver does not stall. A new vector is not taken until the forward
// pass has issued the last result of the previous one.
// Reset: synchronous, active high; clears the element count, the pass counter,
// the truncation flag, the state and the result valid. Cell contents are not reset.
// ----------------------------------------------------------------------------
// product_except_self
// Product of all other vector elements per position, without division.
// ----------------------------------------------------------------------------
module product_except_self
   import pes_pkg::*;
#(
   parameter int MAX_ELEMS = MAX_ELEMS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_product_value,
   output logic                     rsp_end_of_vector,
   output logic                     rsp_truncated
);

   localparam int CW = $clog2(MAX_ELEMS + 1);

   typedef enum logic [1:0] {ST_LOAD, ST_BACK, ST_FWD} state_type;

   state_type         state_ff;
   logic [CW-1:0]     cnt_ff, rem_ff;
   logic              trunc_ff;
   logic [DATA_W-1:0] cur_ff;
   logic              rsp_valid_ff, rsp_eov_ff, rsp_trunc_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [DATA_W-1:0] a_q  [MAX_ELEMS];
   logic [DATA_W-1:0] be_q [MAX_ELEMS];
   logic [DATA_W-1:0] bs_q [MAX_ELEMS];

   pes_ctrl_type      ctrl;
   logic              req_xfer, out_free, can_push;
   logic [DATA_W-1:0] cur_in, out_in;
   logic [DATA_W-1:0] b_in_e, b_in_s;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign can_push  = cnt_ff < CW'(MAX_ELEMS);

   assign cur_in = cur_ff * ((state_ff == ST_BACK) ? a_q[0] : be_q[0]);
   assign out_in = cur_ff * bs_q[0];

   always_comb begin
      ctrl.a_push = req_xfer && can_push;
      ctrl.a_pop  = (state_ff == ST_BACK);
      ctrl.b_push = (state_ff == ST_BACK);
      ctrl.b_pop  = (state_ff == ST_FWD) && out_free;
   end

   assign b_in_e = a_q[0];
   assign b_in_s = cur_ff;

   for (genvar k = 0; k < MAX_ELEMS; k++) begin : g_cell
      logic [DATA_W-1:0] al, ar, bel, ber, bsl, bsr;
      if (k == 0) begin : g_head
         assign al  = req_element_value;
         assign bel = b_in_e;
         assign bsl = b_in_s;
      end else begin : g_body
         assign al  = a_q[k-1];
         assign bel = be_q[k-1];
         assign bsl = bs_q[k-1];
      end
      if (k == MAX_ELEMS - 1) begin : g_tail
         assign ar  = '0;
         assign ber = '0;
         assign bsr = '0;
      end else begin : g_mid
         assign ar  = a_q[k+1];
         assign ber = be_q[k+1];
         assign bsr = bs_q[k+1];
      end
      pes_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .a_left   (al),
         .a_right  (ar),
         .be_left  (bel),
         .be_right (ber),
         .bs_left  (bsl),
         .bs_right (bsr),
         .a_out    (a_q[k]),
         .be_out   (be_q[k]),
         .bs_out   (bs_q[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FWD)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_xfer) begin
                  if (can_push) begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end else begin
                     trunc_ff <= 1'b1;
                  end
                  if (req_is_last) begin
                     state_ff <= ST_BACK;
                     cur_ff   <= DATA_W'(1);
                     rem_ff   <= can_push ? cnt_ff + CW'(1) : cnt_ff;
                  end
               end
            end
            ST_BACK: begin
               if (rem_ff == CW'(1)) begin
                  state_ff <= ST_FWD;
                  cur_ff   <= DATA_W'(1);
                  rem_ff   <= cnt_ff;
               end else begin
                  cur_ff <= cur_in;
                  rem_ff <= rem_ff - CW'(1);
               end
            end
            ST_FWD: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= out_in;
                  rsp_eov_ff   <= (rem_ff == CW'(1));
                  rsp_trunc_ff <= trunc_ff;
                  cur_ff       <= cur_in;
                  rem_ff       <= rem_ff - CW'(1);
                  if (rem_ff == CW'(1)) begin
                     state_ff <= ST_LOAD;
                     cnt_ff   <= '0;
                     trunc_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_end_of_vector = rsp_eov_ff;
   assign rsp_truncated     = rsp_trunc_ff;

`ifndef SYNTH
   a_rem_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BACK || state_ff == ST_FWD) |-> rem_ff != '0)
      else $error("pass counter empty during a pass");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ELEMS))
      else $error("element count beyond capacity");
   a_back_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BACK && rem_ff != CW'(1)) |=>
         (state_ff == ST_BACK && rem_ff == $past(rem_ff) - CW'(1)))
      else $error("backward pass skipped a cell");
`endif

endmodule

/* rtl/pes_cell.sv */
// ----------------------------------------------------------------------------
// pes_cell
// One stack cell: holds a loaded element and a reordered element/suffix pair,
// shifting toward or away from the head together with its neighbors.
// ----------------------------------------------------------------------------
module pes_cell
   import pes_pkg::*;
(
   input  logic              clock,
   input  pes_ctrl_type      ctrl,
   input  logic [DATA_W-1:0] a_left,
   input  logic [DATA_W-1:0] a_right,
   input  logic [DATA_W-1:0] be_left,
   input  logic [DATA_W-1:0] be_right,
   input  logic [DATA_W-1:0] bs_left,
   input  logic [DATA_W-1:0] bs_right,
   output logic [DATA_W-1:0] a_out,
   output logic [DATA_W-1:0] be_out,
   output logic [DATA_W-1:0] bs_out
);

   logic [DATA_W-1:0] a_ff, be_ff, bs_ff;

   always_ff @(posedge clock) begin
      if (ctrl.a_push) begin
         a_ff <= a_left;
      end else if (ctrl.a_pop) begin
         a_ff <= a_right;
      end
      if (ctrl.b_push) begin
         be_ff <= be_left;
         bs_ff <= bs_left;
      end else if (ctrl.b_pop) begin
         be_ff <= be_right;
         bs_ff <= bs_right;
      end
   end

   assign a_out  = a_ff;
   assign be_out = be_ff;
   assign bs_out = bs_ff;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives vectors into product_except_self and checks every product against a
// predictor built from prefix and suffix products, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import pes_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP       = MAX_ELEMS_DEF;
   localparam int IDLE_STOP = 20000;

   typedef struct packed {
      logic [DATA_W-1:0] product_value;
      logic              end_of_vector;
      logic              truncated;
   } product_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_element_value = '0;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_product_value;
   logic                     rsp_end_of_vector;
   logic                     rsp_truncated;

   logic [DATA_W-1:0] vector_held[$];
   logic              dropped_seen = 1'b0;
   product_type       products_due[$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                quiet_mode = 1'b0;

   product_except_self dut (.*);

   always #5 clock = ~clock;

   // Store the element unless full; on the last one queue every product due.
   function automatic void predict_products(logic [DATA_W-1:0] value, logic last);
      logic [DATA_W-1:0] suffix[$];
      logic [DATA_W-1:0] prefix;
      int                n;
      product_type       p;
      if (vector_held.size() < CAP) vector_held.push_back(value);
      else dropped_seen = 1'b1;
      if (!last) return;
      n = vector_held.size();
      suffix = vector_held;
      suffix[n-1] = 1;
      for (int i = n - 1; i > 0; i--) suffix[i-1] = suffix[i] * vector_held[i];
      prefix = 1;
      for (int i = 0; i < n; i++) begin
         p.product_value = prefix * suffix[i];
         p.end_of_vector = (i == n - 1);
         p.truncated     = dropped_seen;
         products_due.push_back(p);
         prefix = prefix * vector_held[i];
      end
      vector_held.delete();
      dropped_seen = 1'b0;
   endfunction

   // The valid stays high after a transfer until the next call drops it or
   // puts the next item in its place.
   task automatic send_element(logic [DATA_W-1:0] value, logic last);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= value;
      req_is_last       <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_products(value, last);
   endtask

   function automatic logic [DATA_W-1:0] random_element();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 6) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vector(int len);
      for (int i = 0; i < len; i++) send_element(random_element(), i == len - 1);
   endtask

   task automatic test_single_element();
      send_element(32'h8000_0000, 1'b1);
      send_element(32'h0000_0000, 1'b1);
   endtask

   task automatic test_extremes_and_zeros();
      send_element(32'h7FFF_FFFF, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'hFFFF_FFFF, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h0000_0005, 1'b1);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h5555_AAAA, 1'b1);
   endtask

   task automatic test_full_and_overflow();
      send_vector(CAP);
      send_vector(CAP + 3);
   endtask

   task automatic test_random_vectors();
      int sent;
      int len;
      sent = 0;
      while (sent < 64) begin
         quiet_mode = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CAP + 2)
                                           : $urandom_range(1, 8);
         send_vector(len);
         sent += len;
      end
      quiet_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (products_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %b %b", $time,
                  rsp_product_value, rsp_end_of_vector, rsp_truncated);
               error_count++;
            end else begin
               product_type p;
               p = products_due.pop_front();
               if (rsp_product_value !== p.product_value) begin
                  $display("%0t: product_value expected %h actual %h", $time,
                     p.product_value, rsp_product_value);
                  error_count++;
               end
               if (rsp_end_of_vector !== p.end_of_vector) begin
                  $display("%0t: end_of_vector expected %b actual %b", $time,
                     p.end_of_vector, rsp_end_of_vector);
                  error_count++;
               end
               if (rsp_truncated !== p.truncated) begin
                  $display("%0t: truncated expected %b actual %b", $time,
                     p.truncated, rsp_truncated);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver stall: a random number of stalled cycles before each transfer.
   initial begin
      int hold;
      forever begin
         hold = quiet_mode ? 0 : $urandom_range(0, 17);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_STOP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_element();
      test_extremes_and_zeros();
      test_full_and_overflow();
      test_random_vectors();
      req_valid <= 1'b0;
      while (products_due.size() != 0) @(posedge clock);
      repeat (3 * CAP + 10) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
rtl/pes_pkg.sv
rtl/pes_cell.sv
rtl/product_except_self.sv
tb/tb_top.sv
